// ===== rtl/wpfe_pkg.sv =====
// ============================================================================
// WS2812 pixel fade encoder package
// Shared constants, types and arithmetic helpers for the pixel encoder.
// ============================================================================
package wpfe_pkg;

   // Pixel store size and fade step.
   localparam int MAX_LEDS  = 256;
   localparam int FADE_STEP = 12;

   // Field widths fixed by the interface.
   localparam int IDX_W    = 8;
   localparam int COLOR_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int BRIGHT_W = 8;
   localparam int ADDR_W   = 13;
   localparam int DUTY_W   = 16;
   localparam int CNT_W    = 9;
   localparam int STORE_AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CMP_W    = 14;

   // Brightness scaling: c * b / 100 equals (c * b * 5243) >> 19 for c * b up to 25500.
   localparam int BRIGHT_MAX = 100;
   localparam int BK_MULT    = 5243;
   localparam int BK_SHIFT   = 19;
   localparam int BK_W       = 20;
   localparam int PROD_W     = CHAN_W + BK_W;

   // Serializer bit counts, minus one.
   localparam int BITCNT_W    = 5;
   localparam int LAST_RGBW   = 31;
   localparam int LAST_RGB    = 23;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STRIP_IS_RGBW = 2'd0,
      REG_LED_COUNT     = 2'd1,
      REG_ZERO_DUTY     = 2'd2,
      REG_ONE_DUTY      = 2'd3
   } csr_reg_type;

   localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 16'd31;
   localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 16'd72;

   // Live configuration.
   typedef struct packed {
      logic              strip_is_rgbw;
      logic [CNT_W-1:0]  led_count;
      logic [DUTY_W-1:0] zero_duty;
      logic [DUTY_W-1:0] one_duty;
   } cfg_type;

   // Faded pixel handed from the fade stage to the scale stage.
   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [COLOR_W-1:0] color;
      logic [BK_W-1:0]    bk;
   } pix_type;

   // Packed bit word handed from the scale stage to the serializer.
   typedef struct packed {
      logic [COLOR_W-1:0]  word;
      logic [ADDR_W-1:0]   base;
      logic [BITCNT_W-1:0] last_cnt;
   } ser_type;

   // Move one channel toward its target by at most FADE_STEP.
   function automatic logic [CHAN_W-1:0] chan_toward(input logic [CHAN_W-1:0] cur,
                                                     input logic [CHAN_W-1:0] tgt);
      logic [CHAN_W-1:0] step;
      logic [CHAN_W-1:0] res;
      step = CHAN_W'(FADE_STEP);
      if (cur < tgt) begin
         res = ((tgt - cur) < step) ? tgt : cur + step;
      end else if (cur > tgt) begin
         res = ((cur - tgt) < step) ? tgt : cur - step;
      end else begin
         res = tgt;
      end
      return res;
   endfunction

   // Fade all four channels independently.
   function automatic logic [COLOR_W-1:0] fade_color(input logic [COLOR_W-1:0] cur,
                                                     input logic [COLOR_W-1:0] tgt);
      logic [COLOR_W-1:0] res;
      res = '0;
      for (int ch = 0; ch < COLOR_W / CHAN_W; ch++) begin
         res[ch*CHAN_W +: CHAN_W] = chan_toward(cur[ch*CHAN_W +: CHAN_W],
                                                tgt[ch*CHAN_W +: CHAN_W]);
      end
      return res;
   endfunction

   // Saturate brightness to 100 and turn it into a reciprocal-scaled factor.
   function automatic logic [BK_W-1:0] bright_factor(input logic [BRIGHT_W-1:0] pct);
      logic [BRIGHT_W-1:0] sat;
      sat = (pct > BRIGHT_W'(BRIGHT_MAX)) ? BRIGHT_W'(BRIGHT_MAX) : pct;
      return BK_W'(sat) * BK_W'(BK_MULT);
   endfunction

   // Scale one channel by a brightness factor.
   function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] chan,
                                                    input logic [BK_W-1:0]   bk);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(chan) * PROD_W'(bk);
      return prod[BK_SHIFT +: CHAN_W];
   endfunction

endpackage

// ===== rtl/wpfe_if.sv =====
// ============================================================================
// WS2812 pixel fade encoder channels
// Valid/ready channel interfaces for pixel writes and bit timing words.
// ============================================================================

// Pixel write channel.
interface wpfe_req_if;
   logic                           valid;
   logic                           ready;
   logic [wpfe_pkg::IDX_W-1:0]     led_index;
   logic [wpfe_pkg::COLOR_W-1:0]   target_color;
   logic [wpfe_pkg::BRIGHT_W-1:0]  brightness_pct;
   logic                           fade_enable;

   modport source(output valid, led_index, target_color, brightness_pct, fade_enable,
                  input ready);
   modport sink(input valid, led_index, target_color, brightness_pct, fade_enable,
                output ready);
endinterface

// Bit timing word channel.
interface wpfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wpfe_pkg::ADDR_W-1:0]  bit_address;
   logic [wpfe_pkg::DUTY_W-1:0]  duty_word;
   logic                         last_bit;

   modport source(output valid, bit_address, duty_word, last_bit, input ready);
   modport sink(input valid, bit_address, duty_word, last_bit, output ready);
endinterface

// ===== rtl/wpfe_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module wpfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wpfe_fade.sv =====
// ============================================================================
// WS2812 pixel fade stage
// Takes pixel writes, reads the stored color, fades it and writes it back.
// ============================================================================
module wpfe_fade (
   input  logic                 clock,
   input  logic                 reset,
   wpfe_req_if.sink             req,
   input  wpfe_pkg::cfg_type    cfg,
   output logic                 pix_valid,
   input  logic                 pix_ready,
   output wpfe_pkg::pix_type    pix_data
);

   localparam int AW = wpfe_pkg::STORE_AW;

   logic                            accept;
   logic                            in_range;
   logic                            s1_adv;
   logic [wpfe_pkg::CMP_W-1:0]      limit;

   logic                            s1_valid_ff, s1_valid_in;
   logic [wpfe_pkg::IDX_W-1:0]      s1_idx_ff;
   logic [wpfe_pkg::COLOR_W-1:0]    s1_tgt_ff;
   logic [wpfe_pkg::BK_W-1:0]       s1_bk_ff;
   logic                            s1_fade_ff;
   logic                            byp_hit_ff, byp_hit_in;
   logic [wpfe_pkg::COLOR_W-1:0]    byp_ff;

   logic [wpfe_pkg::MAX_LEDS-1:0]   vbit_ff, vbit_in;
   logic [wpfe_pkg::COLOR_W-1:0]    ram_q;
   logic [wpfe_pkg::COLOR_W-1:0]    cur_color;
   logic [wpfe_pkg::COLOR_W-1:0]    new_color;
   logic [AW-1:0]                   s1_addr;

   // Index range check against the active LED count, bounded by the store size.
   always_comb begin
      if (wpfe_pkg::CMP_W'(cfg.led_count) > wpfe_pkg::CMP_W'(wpfe_pkg::MAX_LEDS)) begin
         limit = wpfe_pkg::CMP_W'(wpfe_pkg::MAX_LEDS);
      end else begin
         limit = wpfe_pkg::CMP_W'(cfg.led_count);
      end
      in_range = wpfe_pkg::CMP_W'(req.led_index) < limit;
   end

   // Handshake: the stage frees up in the same cycle that it hands on its pixel.
   assign s1_adv    = s1_valid_ff & pix_ready;
   assign req.ready = ~s1_valid_ff | s1_adv;
   assign accept    = req.valid & req.ready;

   // A pixel written back as the next one is read must be forwarded.
   assign byp_hit_in = s1_adv && (s1_idx_ff == req.led_index);

   always_comb begin
      if (accept && in_range) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff  <= req.led_index;
         s1_tgt_ff  <= req.target_color;
         s1_bk_ff   <= wpfe_pkg::bright_factor(req.brightness_pct);
         s1_fade_ff <= req.fade_enable;
         byp_hit_ff <= byp_hit_in;
         byp_ff     <= new_color;
      end
   end

   // Color store.
   assign s1_addr = AW'(s1_idx_ff);

   wpfe_ram #(
      .WIDTH (wpfe_pkg::COLOR_W),
      .DEPTH (wpfe_pkg::MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr),
      .wr_data (new_color),
      .rd_en   (accept),
      .rd_addr (AW'(req.led_index)),
      .rd_data (ram_q)
   );

   // Written flags: an entry never written reads as zero.
   always_comb begin
      vbit_in = vbit_ff;
      if (s1_adv) begin
         vbit_in[s1_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbit_ff <= '0;
      end else begin
         vbit_ff <= vbit_in;
      end
   end

   // Current color and the fade toward the target.
   always_comb begin
      if (byp_hit_ff) begin
         cur_color = byp_ff;
      end else if (vbit_ff[s1_addr]) begin
         cur_color = ram_q;
      end else begin
         cur_color = '0;
      end
      new_color = s1_fade_ff ? wpfe_pkg::fade_color(cur_color, s1_tgt_ff) : s1_tgt_ff;
   end

   assign pix_valid      = s1_valid_ff;
   assign pix_data.idx   = s1_idx_ff;
   assign pix_data.color = new_color;
   assign pix_data.bk    = s1_bk_ff;

endmodule

// ===== rtl/wpfe_scale.sv =====
// ============================================================================
// WS2812 pixel scale stage
// Scales the faded color by brightness and packs it in GRB or GRBW order.
// ============================================================================
module wpfe_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  wpfe_pkg::cfg_type    cfg,
   input  logic                 pix_valid,
   output logic                 pix_ready,
   input  wpfe_pkg::pix_type    pix_data,
   output logic                 ser_valid,
   input  logic                 ser_ready,
   output wpfe_pkg::ser_type    ser_data
);

   logic                          s2_valid_ff, s2_valid_in;
   wpfe_pkg::pix_type             s2_pix_ff;
   logic [wpfe_pkg::CHAN_W-1:0]   w_s, r_s, g_s, b_s;
   logic [wpfe_pkg::ADDR_W-1:0]   idx_ext;

   // Stage register handshake.
   assign pix_ready = ~s2_valid_ff | ser_ready;

   always_comb begin
      if (pix_ready) begin
         s2_valid_in = pix_valid;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_ready && pix_valid) begin
         s2_pix_ff <= pix_data;
      end
   end

   // One multiplier per channel against the brightness factor.
   assign w_s = wpfe_pkg::scale_chan(s2_pix_ff.color[31:24], s2_pix_ff.bk);
   assign r_s = wpfe_pkg::scale_chan(s2_pix_ff.color[23:16], s2_pix_ff.bk);
   assign g_s = wpfe_pkg::scale_chan(s2_pix_ff.color[15:8], s2_pix_ff.bk);
   assign b_s = wpfe_pkg::scale_chan(s2_pix_ff.color[7:0], s2_pix_ff.bk);

   assign idx_ext = wpfe_pkg::ADDR_W'(s2_pix_ff.idx);

   // Reorder, left-aligned so the first bit sent is always bit 31.
   always_comb begin
      if (cfg.strip_is_rgbw) begin
         ser_data.word     = {g_s, r_s, b_s, w_s};
         ser_data.base     = idx_ext << 5;
         ser_data.last_cnt = wpfe_pkg::BITCNT_W'(wpfe_pkg::LAST_RGBW);
      end else begin
         ser_data.word     = {g_s, r_s, b_s, 8'h00};
         ser_data.base     = (idx_ext << 4) + (idx_ext << 3);
         ser_data.last_cnt = wpfe_pkg::BITCNT_W'(wpfe_pkg::LAST_RGB);
      end
   end

   assign ser_valid = s2_valid_ff;

endmodule

// ===== rtl/wpfe_serial.sv =====
// ============================================================================
// WS2812 bit serializer
// Shifts the packed pixel out MSB first, one duty word beat per cycle if ready.
// ============================================================================
module wpfe_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  wpfe_pkg::cfg_type    cfg,
   input  logic                 ser_valid,
   output logic                 ser_ready,
   input  wpfe_pkg::ser_type    ser_data,
   wpfe_rsp_if.source           rsp
);

   logic                              v_ff, v_in;
   logic [wpfe_pkg::COLOR_W-1:0]      sh_ff, sh_in;
   logic [wpfe_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [wpfe_pkg::BITCNT_W-1:0]     cnt_ff, cnt_in;
   logic                              ack;
   logic                              can_load;

   // A new pixel loads when the output is empty or its last beat leaves.
   assign ack       = v_ff & rsp.ready;
   assign can_load  = ~v_ff | (rsp.ready & (cnt_ff == '0));
   assign ser_ready = can_load;

   always_comb begin
      v_in    = v_ff;
      sh_in   = sh_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      if (can_load) begin
         v_in    = ser_valid;
         sh_in   = ser_data.word;
         addr_in = ser_data.base;
         cnt_in  = ser_data.last_cnt;
      end else if (ack) begin
         sh_in   = sh_ff << 1;
         addr_in = addr_ff + 1'b1;
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
   end

   // Output beat.
   assign rsp.valid       = v_ff;
   assign rsp.bit_address = addr_ff;
   assign rsp.duty_word   = sh_ff[wpfe_pkg::COLOR_W-1] ? cfg.one_duty : cfg.zero_duty;
   assign rsp.last_bit    = (cnt_ff == '0);

endmodule

// ===== rtl/ws2812_pixel_fade_encoder.sv =====
// ============================================================================
// WS2812 pixel fade encoder
// Fades, scales and reorders one pixel write and emits its bit timing words.
// ============================================================================
// The first beat of a pixel is valid after the fade, scale and serializer registers.
// A pixel is 24 beats (GRB) or 32 beats (GRBW), one beat per cycle while the output
// is ready, set by the bit serializer; a write with an index out of range is dropped.
// Pixel writes are accepted while earlier pixels are still being serialized.
// Reset is synchronous: registers take their reset values, the pipeline empties,
// and every stored color reads as zero until written again.
module ws2812_pixel_fade_encoder (
   input  logic                            clock,
   input  logic                            reset,
   wpfe_req_if.sink                        req_bus,
   wpfe_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [wpfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpfe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wpfe_pkg::cfg_type cfg_ff, cfg_in;
   logic              pix_valid, pix_ready;
   wpfe_pkg::pix_type pix_data;
   logic              ser_valid, ser_ready;
   wpfe_pkg::ser_type ser_data;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (wpfe_pkg::csr_reg_type'(csr_index))
            wpfe_pkg::REG_STRIP_IS_RGBW: cfg_in.strip_is_rgbw = csr_wdata[0];
            wpfe_pkg::REG_LED_COUNT:     cfg_in.led_count = csr_wdata[wpfe_pkg::CNT_W-1:0];
            wpfe_pkg::REG_ZERO_DUTY:     cfg_in.zero_duty = csr_wdata[wpfe_pkg::DUTY_W-1:0];
            wpfe_pkg::REG_ONE_DUTY:      cfg_in.one_duty = csr_wdata[wpfe_pkg::DUTY_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strip_is_rgbw <= 1'b0;
         cfg_ff.led_count     <= '0;
         cfg_ff.zero_duty     <= wpfe_pkg::ZERO_DUTY_RST;
         cfg_ff.one_duty      <= wpfe_pkg::ONE_DUTY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Fade stage with the color store.
   wpfe_fade u_fade (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cfg       (cfg_ff),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_data  (pix_data)
   );

   // Brightness scale and channel reorder.
   wpfe_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_data  (pix_data),
      .ser_valid (ser_valid),
      .ser_ready (ser_ready),
      .ser_data  (ser_data)
   );

   // Bit serializer.
   wpfe_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ser_valid (ser_valid),
      .ser_ready (ser_ready),
      .ser_data  (ser_data),
      .rsp       (rsp_bus)
   );

endmodule

// ===== rtl/wpfe_checker.sv =====
// ============================================================================
// WS2812 pixel fade encoder checker
// Port-level assertions on the encoder, attached to the top level by bind.
// ============================================================================
module wpfe_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [wpfe_pkg::ADDR_W-1:0]   rsp_bit_address,
   input logic [wpfe_pkg::DUTY_W-1:0]   rsp_duty_word,
   input logic                          rsp_last_bit
);

   // Out of reset the pipeline is empty and ready for a pixel.
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("encoder not empty after reset");

   // A stalled beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bit_address)
         && $stable(rsp_duty_word) && $stable(rsp_last_bit))
      else $error("stalled beat changed");

   // Within a pixel the beats follow back to back at consecutive addresses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_bit |=>
         rsp_valid && (rsp_bit_address == $past(rsp_bit_address) + 1'b1))
      else $error("pixel beats not contiguous");

   // The last bit of a 24- or 32-bit pixel always sits at an address ending in 7.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bit |-> rsp_bit_address[2:0] == 3'b111)
      else $error("last bit at wrong address");

endmodule

bind ws2812_pixel_fade_encoder wpfe_checker u_wpfe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_bit_address (rsp_bus.bit_address),
   .rsp_duty_word   (rsp_bus.duty_word),
   .rsp_last_bit    (rsp_bus.last_bit)
);
